// ----- rtl/core/rbi_pkg.sv -----
package rbi_pkg;

    localparam int WORD_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int STEP_FRAC = 16;
    localparam int AXES      = 3;
    localparam int PADDR_W   = 5;
    localparam int OUT_W     = 6 * WORD_W;

    localparam logic [1:0] AXIS_X   = 2'd0;
    localparam logic [1:0] AXIS_Y   = 2'd1;
    localparam logic [1:0] AXIS_ANG = 2'd2;

    localparam logic [1:0] BODY_STATIC     = 2'd0;
    localparam logic [1:0] BODY_KINEMATIC  = 2'd1;
    localparam logic [1:0] BODY_DYNAMIC    = 2'd2;
    localparam logic [1:0] BODY_STATIC_ALT = 2'd3;

    localparam logic [2:0] REG_BODY_TYPE   = 3'd0;
    localparam logic [2:0] REG_INV_MASS    = 3'd1;
    localparam logic [2:0] REG_INV_INERTIA = 3'd2;
    localparam logic [2:0] REG_TIME_STEP   = 3'd3;
    localparam logic [2:0] REG_LIN_DECAY   = 3'd4;
    localparam logic [2:0] REG_ANG_DECAY   = 3'd5;

    typedef enum logic [2:0] {
        ACT_TICK,
        ACT_FORCE,
        ACT_TORQUE,
        ACT_IMPULSE,
        ACT_SET_VEL,
        ACT_SET_SPIN,
        ACT_SET_POS,
        ACT_SET_ROT
    } action_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SIMPLE,
        OP_MUL_FI,
        OP_MUL_HI,
        OP_MUL_LO,
        OP_ADD_V,
        OP_MUL_DEC,
        OP_WR_DEC,
        OP_MUL_TRV,
        OP_WR_POS,
        OP_MUL_IMP,
        OP_WR_IMP,
        OP_CLR_LOAD,
        OP_LOAD_OUT
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FI,
        S_HI,
        S_LO,
        S_ADDV,
        S_DEC,
        S_WRDEC,
        S_TRV,
        S_WRPOS,
        S_IMP,
        S_WRIMP,
        S_CLEAR,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic [1:0]  body_type;
        logic [30:0] inv_mass;
        logic [30:0] inv_inertia;
        logic [15:0] time_step;
        logic [16:0] lin_decay;
        logic [16:0] ang_decay;
    } cfg_t;

    typedef struct packed {
        logic clear_vel;
        logic clear_load;
    } bt_evt_t;

    typedef struct packed {
        logic       load_in;
        dp_op_t     op;
        logic [1:0] axis;
    } cmd_t;

    typedef struct packed {
        action_t    action;
        logic [1:0] body_type;
        logic       dt_zero;
        logic       out_free;
    } status_t;

    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [63:0] v);
        logic signed [63:0] hi_lim;
        logic signed [63:0] lo_lim;
        hi_lim = (64'sd1 <<< (WORD_W - 1)) - 64'sd1;
        lo_lim = -hi_lim - 64'sd1;
        if (v > hi_lim)
        begin
            return hi_lim[WORD_W-1:0];
        end
        else if (v < lo_lim)
        begin
            return lo_lim[WORD_W-1:0];
        end
        return v[WORD_W-1:0];
    endfunction

endpackage

// ----- rtl/core/rbi_regs.sv -----
module rbi_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rbi_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output rbi_pkg::cfg_t               cfg,
    output rbi_pkg::bt_evt_t            bt_evt
);
    import rbi_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[PADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.body_type   <= BODY_DYNAMIC;
            cfg_reg.inv_mass    <= 31'd65536;
            cfg_reg.inv_inertia <= 31'd0;
            cfg_reg.time_step   <= 16'd1092;
            cfg_reg.lin_decay   <= 17'd65536;
            cfg_reg.ang_decay   <= 17'd65536;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_BODY_TYPE:   cfg_reg.body_type   <= pwdata[1:0];
                REG_INV_MASS:    cfg_reg.inv_mass    <= pwdata[30:0];
                REG_INV_INERTIA: cfg_reg.inv_inertia <= pwdata[30:0];
                REG_TIME_STEP:   cfg_reg.time_step   <= pwdata[15:0];
                REG_LIN_DECAY:   cfg_reg.lin_decay   <= pwdata[16:0];
                REG_ANG_DECAY:   cfg_reg.ang_decay   <= pwdata[16:0];
                default:         ;
            endcase
        end
    end

    // static types drop velocities, anything but dynamic drops the loads
    always_comb
    begin
        bt_evt.clear_vel  = wr_en && (idx == REG_BODY_TYPE) &&
                            ((pwdata[1:0] == BODY_STATIC) || (pwdata[1:0] == BODY_STATIC_ALT));
        bt_evt.clear_load = wr_en && (idx == REG_BODY_TYPE) && (pwdata[1:0] != BODY_DYNAMIC);
    end

    always_comb
    begin
        case (idx)
            REG_BODY_TYPE:   prdata = {30'd0, cfg_reg.body_type};
            REG_INV_MASS:    prdata = {1'b0, cfg_reg.inv_mass};
            REG_INV_INERTIA: prdata = {1'b0, cfg_reg.inv_inertia};
            REG_TIME_STEP:   prdata = {16'd0, cfg_reg.time_step};
            REG_LIN_DECAY:   prdata = {15'd0, cfg_reg.lin_decay};
            REG_ANG_DECAY:   prdata = {15'd0, cfg_reg.ang_decay};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

// ----- rtl/core/rbi_ctrl.sv -----
module rbi_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  rbi_pkg::status_t status,
    output rbi_pkg::cmd_t    cmd
);
    import rbi_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic [1:0]  axis_reg;
    logic [1:0]  axis_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= AXIS_X;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                axis_next = AXIS_X;
                case (status.action)
                    ACT_TICK:
                    begin
                        if (status.dt_zero)
                        begin
                            state_next = S_DONE;
                        end
                        else if (status.body_type == BODY_DYNAMIC)
                        begin
                            state_next = S_FI;
                        end
                        else if (status.body_type == BODY_KINEMATIC)
                        begin
                            state_next = S_TRV;
                        end
                        else
                        begin
                            state_next = S_CLEAR;
                        end
                    end
                    ACT_IMPULSE: state_next = S_IMP;
                    default:     state_next = S_DONE;
                endcase
            end
            S_FI:    state_next = S_HI;
            S_HI:    state_next = S_LO;
            S_LO:    state_next = S_ADDV;
            S_ADDV:  state_next = S_DEC;
            S_DEC:   state_next = S_WRDEC;
            S_WRDEC:
            begin
                if (axis_reg == AXIS_ANG)
                begin
                    axis_next  = AXIS_X;
                    state_next = S_TRV;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_FI;
                end
            end
            S_TRV:   state_next = S_WRPOS;
            S_WRPOS:
            begin
                if (axis_reg == AXIS_ANG)
                begin
                    axis_next  = AXIS_X;
                    state_next = S_CLEAR;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_TRV;
                end
            end
            S_IMP:   state_next = S_WRIMP;
            S_WRIMP:
            begin
                if (axis_reg == AXIS_X)
                begin
                    axis_next  = AXIS_Y;
                    state_next = S_IMP;
                end
                else
                begin
                    axis_next  = AXIS_X;
                    state_next = S_DONE;
                end
            end
            S_CLEAR: state_next = S_DONE;
            S_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd.load_in = 1'b0;
        cmd.op      = OP_NONE;
        cmd.axis    = axis_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            S_DECODE: cmd.op = OP_SIMPLE;
            S_FI:     cmd.op = OP_MUL_FI;
            S_HI:     cmd.op = OP_MUL_HI;
            S_LO:     cmd.op = OP_MUL_LO;
            S_ADDV:   cmd.op = OP_ADD_V;
            S_DEC:    cmd.op = OP_MUL_DEC;
            S_WRDEC:  cmd.op = OP_WR_DEC;
            S_TRV:    cmd.op = OP_MUL_TRV;
            S_WRPOS:  cmd.op = OP_WR_POS;
            S_IMP:    cmd.op = OP_MUL_IMP;
            S_WRIMP:  cmd.op = OP_WR_IMP;
            S_CLEAR:  cmd.op = OP_CLR_LOAD;
            S_DONE:   cmd.op = status.out_free ? OP_LOAD_OUT : OP_NONE;
            default:  cmd.op = OP_NONE;
        endcase
    end

    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        axis_reg != 2'd3)
        else $error("axis counter out of range");

    a_decode_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECODE) |-> $past(in_valid && in_ready))
        else $error("decode entered without an accepted beat");

    a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && status.out_free) |=> (state_reg == S_IDLE))
        else $error("result not released from done");

    a_impulse_two_axes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRIMP && axis_reg == AXIS_X) |=> (state_reg == S_IMP))
        else $error("impulse skipped the y axis");

endmodule

// ----- rtl/core/rbi_datapath.sv -----
module rbi_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rbi_pkg::cmd_t                   cmd,
    input  rbi_pkg::cfg_t                   cfg,
    input  rbi_pkg::bt_evt_t                bt_evt,
    input  logic [2:0]                      in_action,
    input  logic signed [rbi_pkg::WORD_W-1:0] in_x,
    input  logic signed [rbi_pkg::WORD_W-1:0] in_y,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [rbi_pkg::OUT_W-1:0]       out_data,
    output rbi_pkg::status_t                status
);
    import rbi_pkg::*;

    logic signed [WORD_W-1:0] pos_reg  [AXES];
    logic signed [WORD_W-1:0] vel_reg  [AXES];
    logic signed [WORD_W-1:0] load_reg [AXES];

    logic [2:0]               act_reg;
    logic signed [WORD_W-1:0] x_reg;
    logic signed [WORD_W-1:0] y_reg;

    logic signed [63:0]          prod_reg;
    logic [STEP_FRAC-1:0]        lo_reg;
    logic signed [47:0]          hidt_reg;
    logic                        out_valid_reg;
    logic [OUT_W-1:0]            out_data_reg;

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mult_full;
    logic               mul_en;

    logic [30:0]              inv_sel;
    logic [16:0]              decay_sel;
    logic signed [WORD_W-1:0] vel_sel;
    logic signed [WORD_W-1:0] pos_sel;
    logic signed [WORD_W-1:0] load_sel;
    logic signed [WORD_W-1:0] imp_sel;
    logic signed [63:0]       dv;
    logic signed [WORD_W-1:0] vel_add_sat;
    logic signed [WORD_W-1:0] vel_dec_sat;
    logic signed [WORD_W-1:0] vel_imp_sat;
    logic signed [WORD_W-1:0] pos_sat;
    logic signed [WORD_W-1:0] load_x_sat;
    logic signed [WORD_W-1:0] load_y_sat;
    logic signed [WORD_W-1:0] load_t_sat;
    logic                     out_free;

    assign inv_sel   = (cmd.axis == AXIS_ANG) ? cfg.inv_inertia : cfg.inv_mass;
    assign decay_sel = (cmd.axis == AXIS_ANG) ? cfg.ang_decay : cfg.lin_decay;
    assign vel_sel   = vel_reg[cmd.axis];
    assign pos_sel   = pos_reg[cmd.axis];
    assign load_sel  = load_reg[cmd.axis];
    assign imp_sel   = (cmd.axis == AXIS_X) ? x_reg : y_reg;

    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (cmd.op)
            OP_MUL_FI:
            begin
                mul_a = 33'(load_sel);
                mul_b = 33'(inv_sel);
            end
            OP_MUL_HI:
            begin
                // high part of the acceleration: floor(acc / 2^STEP_FRAC)
                mul_a = 33'(prod_reg >>> (FRAC_BITS + STEP_FRAC));
                mul_b = 33'(cfg.time_step);
            end
            OP_MUL_LO:
            begin
                mul_a = 33'(lo_reg);
                mul_b = 33'(cfg.time_step);
            end
            OP_MUL_DEC:
            begin
                mul_a = 33'(vel_sel);
                mul_b = 33'(decay_sel);
            end
            OP_MUL_TRV:
            begin
                mul_a = 33'(vel_sel);
                mul_b = 33'(cfg.time_step);
            end
            OP_MUL_IMP:
            begin
                mul_a = 33'(imp_sel);
                mul_b = 33'(cfg.inv_mass);
            end
            default: mul_en = 1'b0;
        endcase
    end

    assign mult_full = 66'(mul_a) * 66'(mul_b);

    // acc * dt split as hi*dt + floor(lo*dt / 2^STEP_FRAC), lo nonnegative
    assign dv          = 64'(hidt_reg) + (prod_reg >>> STEP_FRAC);
    assign vel_add_sat = sat_word(64'(vel_sel) + dv);
    assign vel_dec_sat = sat_word(prod_reg >>> STEP_FRAC);
    assign vel_imp_sat = sat_word(64'(vel_sel) + (prod_reg >>> FRAC_BITS));
    assign pos_sat     = sat_word(64'(pos_sel) + (prod_reg >>> STEP_FRAC));
    assign load_x_sat  = sat_word(64'(load_reg[AXIS_X]) + 64'(x_reg));
    assign load_y_sat  = sat_word(64'(load_reg[AXIS_Y]) + 64'(y_reg));
    assign load_t_sat  = sat_word(64'(load_reg[AXIS_ANG]) + 64'(x_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                pos_reg[i]  <= '0;
                vel_reg[i]  <= '0;
                load_reg[i] <= '0;
            end
        end
        else
        begin
            case (cmd.op)
                OP_SIMPLE:
                begin
                    case (action_t'(act_reg))
                        ACT_FORCE:
                        begin
                            load_reg[AXIS_X] <= load_x_sat;
                            load_reg[AXIS_Y] <= load_y_sat;
                        end
                        ACT_TORQUE:   load_reg[AXIS_ANG] <= load_t_sat;
                        ACT_SET_VEL:
                        begin
                            vel_reg[AXIS_X] <= x_reg;
                            vel_reg[AXIS_Y] <= y_reg;
                        end
                        ACT_SET_SPIN: vel_reg[AXIS_ANG] <= x_reg;
                        ACT_SET_POS:
                        begin
                            pos_reg[AXIS_X] <= x_reg;
                            pos_reg[AXIS_Y] <= y_reg;
                        end
                        ACT_SET_ROT:  pos_reg[AXIS_ANG] <= x_reg;
                        default:      ;
                    endcase
                end
                OP_ADD_V:  vel_reg[cmd.axis] <= vel_add_sat;
                OP_WR_DEC: vel_reg[cmd.axis] <= vel_dec_sat;
                OP_WR_IMP: vel_reg[cmd.axis] <= vel_imp_sat;
                OP_WR_POS: pos_reg[cmd.axis] <= pos_sat;
                OP_CLR_LOAD:
                begin
                    for (int i = 0; i < AXES; i++)
                    begin
                        load_reg[i] <= '0;
                    end
                end
                default:
                begin
                    if (bt_evt.clear_vel)
                    begin
                        for (int i = 0; i < AXES; i++)
                        begin
                            vel_reg[i] <= '0;
                        end
                    end
                    if (bt_evt.clear_load)
                    begin
                        for (int i = 0; i < AXES; i++)
                        begin
                            load_reg[i] <= '0;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            act_reg <= in_action;
            x_reg   <= in_x;
            y_reg   <= in_y;
        end
        if (mul_en)
        begin
            prod_reg <= mult_full[63:0];
        end
        if (cmd.op == OP_MUL_HI)
        begin
            lo_reg <= prod_reg[FRAC_BITS +: STEP_FRAC];
        end
        if (cmd.op == OP_MUL_LO)
        begin
            hidt_reg <= prod_reg[47:0];
        end
        if (cmd.op == OP_LOAD_OUT)
        begin
            out_data_reg <= {vel_reg[AXIS_ANG], vel_reg[AXIS_Y], vel_reg[AXIS_X],
                             pos_reg[AXIS_ANG], pos_reg[AXIS_Y], pos_reg[AXIS_X]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == OP_LOAD_OUT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        status.action    = action_t'(act_reg);
        status.body_type = cfg.body_type;
        status.dt_zero   = (cfg.time_step == 16'd0);
        status.out_free  = out_free;
    end

    a_load_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_LOAD_OUT) |-> out_free)
        else $error("result loaded over an untaken beat");

    a_clear_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_CLR_LOAD) |=>
        (load_reg[AXIS_X] == '0 && load_reg[AXIS_Y] == '0 && load_reg[AXIS_ANG] == '0))
        else $error("load accumulators not cleared");

endmodule

// ----- rtl/core/rigid_body_2d_integrator.sv -----
// Channel   Dir  Beat contents (low bits first)
// s_axis    in   tuser: action[2:0]; tdata: value_x, value_y
// m_axis    out  tdata: pos_x, pos_y, angle, vel_x, vel_y, spin
// apb       in   six registers at byte addresses 0..20, step 4
//
// One beat is processed at a time on a single shared 33x33 multiplier.
// Set/load actions and zero-step ticks go straight to the result, a static
// tick clears loads, an impulse updates vel_x/vel_y, a kinematic tick moves
// positions and a dynamic tick first updates velocities (five dependent
// products per axis); next beat is taken the cycle after the result loads.
// A finished result waits in the output register while the next beat works.
// Reset clears the body state; registers return to their reset values.
module rigid_body_2d_integrator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [63:0]                 s_axis_tdata,  // value_x, value_y
    input  logic [2:0]                  s_axis_tuser,  // action
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [rbi_pkg::OUT_W-1:0]   m_axis_tdata,  // pos_x, pos_y, angle, vel_x, vel_y, spin
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rbi_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import rbi_pkg::*;

    cfg_t    cfg;
    bt_evt_t bt_evt;
    cmd_t    cmd;
    status_t status;

    rbi_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .bt_evt  (bt_evt)
    );

    rbi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rbi_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg       (cfg),
        .bt_evt    (bt_evt),
        .in_action (s_axis_tuser),
        .in_x      (s_axis_tdata[WORD_W-1:0]),
        .in_y      (s_axis_tdata[2*WORD_W-1:WORD_W]),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .status    (status)
    );

endmodule
